// ===== src/bsfr_pkg.sv =====
`timescale 1ns / 1ps

package bsfr_pkg;

	// Field widths
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned CFG_IDX_W = 2;

	// Register reset values and the smallest usable frame length
	localparam logic [BYTE_W-1:0] FLAG_RESET    = 8'd126;
	localparam logic [BYTE_W-1:0] ESCAPE_RESET  = 8'd125;
	localparam logic [BYTE_W-1:0] MAX_LEN_RESET = 8'd19;
	localparam logic [BYTE_W-1:0] MIN_FRAME_LEN = 8'd2;

	// Queue between the classifier and the frame engine
	localparam int unsigned FIFO_DEPTH = 2;
	localparam int unsigned FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FLAG    = 2'd0,
		CFG_ESCAPE  = 2'd1,
		CFG_MAX_LEN = 2'd2
	} cfg_idx_t;

	// Receiver phase
	typedef enum logic [1:0] {
		PH_HUNT  = 2'd0,
		PH_FRAME = 2'd1,
		PH_ESC   = 2'd2
	} phase_t;

	// A received byte with its classification
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              is_flag;
		logic              is_esc;
	} cls_item_t;

	// One result beat
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              frame_end;
		logic              overflow;
	} result_t;

endpackage

// ===== src/bsfr_if.sv =====
`timescale 1ns / 1ps

// Received byte channel
interface bsfr_rx_if;
	logic                          valid;
	logic                          ready;
	logic [bsfr_pkg::BYTE_W-1:0]   rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel
interface bsfr_res_if;
	logic                          valid;
	logic                          ready;
	logic [bsfr_pkg::BYTE_W-1:0]   data_byte;
	logic                          frame_end;
	logic                          overflow;

	modport source (output valid, output data_byte, output frame_end, output overflow,
		input ready);
	modport sink   (input valid, input data_byte, input frame_end, input overflow,
		output ready);
endinterface

// Configuration write channel
interface bsfr_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [bsfr_pkg::CFG_IDX_W-1:0]  index;
	logic [bsfr_pkg::BYTE_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/byte_stuffed_frame_receiver_core.sv =====
`timescale 1ns / 1ps

// Channel    Dir   Beat carries                        Accepted when
// rx_chan    in    rx_byte                             valid && ready
// res_chan   out   data_byte, frame_end, overflow      valid && ready
// cfg_chan   in    index, data (register write)        valid && ready (ready tied high)
//
// One received byte per cycle is sustained while the result channel takes its beats. A byte
// accepted passes the classifier stage, the two-entry queue and the output register of the
// frame engine before its result is valid and can be taken.
// arst_n clears the stage valid bits, the queue, the phase and the registers to their
// reset values. A stalled result channel holds the frame engine, then the queue fills,
// then rx_chan.ready falls; until then the classifier takes a few more bytes.
module byte_stuffed_frame_receiver_core (
	input  logic        clk,
	input  logic        arst_n,
	bsfr_rx_if.sink     rx_chan,
	bsfr_res_if.source  res_chan,
	bsfr_cfg_if.sink    cfg_chan
);

	logic [bsfr_pkg::BYTE_W-1:0]  flag_q;
	logic [bsfr_pkg::BYTE_W-1:0]  escape_q;
	logic [bsfr_pkg::BYTE_W-1:0]  max_len_q;
	logic                         push_valid;
	logic                         push_ready;
	bsfr_pkg::cls_item_t          push_item;
	logic                         pop_valid;
	logic                         pop_ready;
	bsfr_pkg::cls_item_t          pop_item;
	bsfr_pkg::result_t            out_res;

	// Configuration registers; writes to unknown indexes are dropped.
	assign cfg_chan.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q    <= bsfr_pkg::FLAG_RESET;
			escape_q  <= bsfr_pkg::ESCAPE_RESET;
			max_len_q <= bsfr_pkg::MAX_LEN_RESET;
		end else if (cfg_chan.valid) begin
			unique case (bsfr_pkg::cfg_idx_t'(cfg_chan.index))
				bsfr_pkg::CFG_FLAG:    flag_q    <= cfg_chan.data;
				bsfr_pkg::CFG_ESCAPE:  escape_q  <= cfg_chan.data;
				bsfr_pkg::CFG_MAX_LEN: max_len_q <= cfg_chan.data;
				default: begin
				end
			endcase
		end
	end

	// Classifier.
	bsfr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_valid    (rx_chan.valid),
		.rx_byte     (rx_chan.rx_byte),
		.rx_ready    (rx_chan.ready),
		.flag_byte   (flag_q),
		.escape_byte (escape_q),
		.push_valid  (push_valid),
		.push_item   (push_item),
		.push_ready  (push_ready)
	);

	// Queue between classifier and frame engine.
	bsfr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop_ready  (pop_ready)
	);

	// Frame engine.
	bsfr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_valid     (pop_valid),
		.pop_item      (pop_item),
		.pop_ready     (pop_ready),
		.max_frame_len (max_len_q),
		.out_valid     (res_chan.valid),
		.out_res       (out_res),
		.out_ready     (res_chan.ready)
	);

	assign res_chan.data_byte = out_res.data_byte;
	assign res_chan.frame_end = out_res.frame_end;
	assign res_chan.overflow  = out_res.overflow;

endmodule

// ===== src/bsfr_front.sv =====
`timescale 1ns / 1ps

module bsfr_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rx_valid,
	input  logic [bsfr_pkg::BYTE_W-1:0]   rx_byte,
	output logic                          rx_ready,
	input  logic [bsfr_pkg::BYTE_W-1:0]   flag_byte,
	input  logic [bsfr_pkg::BYTE_W-1:0]   escape_byte,
	output logic                          push_valid,
	output bsfr_pkg::cls_item_t           push_item,
	input  logic                          push_ready
);

	logic                 valid_s1;
	bsfr_pkg::cls_item_t  item_s1;

	// The stage takes a new beat when empty or when its beat moves on.
	assign rx_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	// Compare the byte against the flag and escape values once, here.
	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			item_s1.data    <= rx_byte;
			item_s1.is_flag <= (rx_byte == flag_byte);
			item_s1.is_esc  <= (rx_byte == escape_byte);
		end
	end

endmodule

// ===== src/bsfr_fifo.sv =====
`timescale 1ns / 1ps

module bsfr_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	input  bsfr_pkg::cls_item_t  push_item,
	output logic                 push_ready,
	output logic                 pop_valid,
	output bsfr_pkg::cls_item_t  pop_item,
	input  logic                 pop_ready
);

	bsfr_pkg::cls_item_t                 mem_q [bsfr_pkg::FIFO_DEPTH];
	logic [bsfr_pkg::FIFO_PTR_W-1:0]     wr_ptr_q;
	logic [bsfr_pkg::FIFO_PTR_W-1:0]     rd_ptr_q;
	logic [bsfr_pkg::FIFO_CNT_W-1:0]     count_q;
	logic                                push_fire;
	logic                                pop_fire;

	assign push_ready = (count_q != bsfr_pkg::FIFO_CNT_W'(bsfr_pkg::FIFO_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				if (wr_ptr_q == bsfr_pkg::FIFO_PTR_W'(bsfr_pkg::FIFO_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (pop_fire) begin
				if (rd_ptr_q == bsfr_pkg::FIFO_PTR_W'(bsfr_pkg::FIFO_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + 1'b1;
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== src/bsfr_back.sv =====
`timescale 1ns / 1ps

module bsfr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pop_valid,
	input  bsfr_pkg::cls_item_t           pop_item,
	output logic                          pop_ready,
	input  logic [bsfr_pkg::BYTE_W-1:0]   max_frame_len,
	output logic                          out_valid,
	output bsfr_pkg::result_t             out_res,
	input  logic                          out_ready
);

	bsfr_pkg::phase_t                phase_q;
	bsfr_pkg::phase_t                phase_d;
	logic [bsfr_pkg::BYTE_W-1:0]     count_q;
	logic [bsfr_pkg::BYTE_W-1:0]     count_d;
	logic [bsfr_pkg::BYTE_W-1:0]     limit;
	logic                            at_limit;
	logic                            emit;
	bsfr_pkg::result_t               res_d;
	logic                            out_valid_q;
	bsfr_pkg::result_t               out_res_q;
	logic                            fire;

	// The output register frees up when empty or when its beat is taken.
	assign pop_ready = !out_valid_q || out_ready;
	assign fire      = pop_valid && pop_ready;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	// A limit below the minimum counts as the minimum.
	assign limit    = (max_frame_len < bsfr_pkg::MIN_FRAME_LEN) ?
		bsfr_pkg::MIN_FRAME_LEN : max_frame_len;
	assign at_limit = (count_q >= limit);

	// Next phase, byte count and result for the beat at the queue head.
	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		emit    = 1'b0;
		res_d   = '{data_byte: pop_item.data, frame_end: 1'b0, overflow: 1'b0};
		unique case (phase_q)
			bsfr_pkg::PH_FRAME, bsfr_pkg::PH_ESC: begin
				if (phase_q == bsfr_pkg::PH_FRAME && pop_item.is_esc) begin
					phase_d = bsfr_pkg::PH_ESC;
				end else begin
					emit = 1'b1;
					if (at_limit) begin
						// Frame too long: cut it with an overflow beat.
						phase_d = bsfr_pkg::PH_HUNT;
						count_d = '0;
						res_d   = '{data_byte: '0, frame_end: 1'b1, overflow: 1'b1};
					end else if (phase_q == bsfr_pkg::PH_FRAME && pop_item.is_flag) begin
						// Closing flag.
						phase_d         = bsfr_pkg::PH_HUNT;
						count_d         = '0;
						res_d.frame_end = 1'b1;
					end else begin
						phase_d = bsfr_pkg::PH_FRAME;
						count_d = count_q + 1'b1;
					end
				end
			end
			default: begin
				// Hunting: only a flag opens a frame.
				phase_d = bsfr_pkg::PH_HUNT;
				if (pop_item.is_flag) begin
					emit    = 1'b1;
					phase_d = bsfr_pkg::PH_FRAME;
					count_d = 8'd1;
				end
			end
		endcase
	end

	// Phase and count registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bsfr_pkg::PH_HUNT;
			count_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			count_q <= count_d;
		end
	end

	// Output valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_ready) begin
			out_valid_q <= fire && emit;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (fire && emit) begin
			out_res_q <= res_d;
		end
	end

endmodule

// ===== src/bsfr_checker.sv =====
`timescale 1ns / 1ps

module bsfr_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          res_valid,
	input  logic                          res_ready,
	input  logic [bsfr_pkg::BYTE_W-1:0]   data_byte,
	input  logic                          frame_end,
	input  logic                          overflow
);

	// A stalled result beat stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(data_byte) && $stable(frame_end)
			&& $stable(overflow))
		else $error("result beat changed while stalled");

	// An overflow beat ends the frame and carries a zero byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && overflow |-> frame_end && (data_byte == '0))
		else $error("overflow beat without frame end or with data");

	// No result straight out of reset.
	assert property (@(posedge clk)
		$rose(arst_n) |-> !res_valid)
		else $error("result valid right after reset");

endmodule

bind byte_stuffed_frame_receiver_core bsfr_checker u_bsfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_chan.valid),
	.res_ready (res_chan.ready),
	.data_byte (res_chan.data_byte),
	.frame_end (res_chan.frame_end),
	.overflow  (res_chan.overflow)
);

// ===== tb/byte_stuffed_frame_receiver_core_tb.sv =====
`timescale 1ns / 1ps

module byte_stuffed_frame_receiver_core_tb;

	localparam int unsigned RANDOM_ITEMS  = 525;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned STALL_LIMIT   = 1000;
	localparam logic [bsfr_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	// What a directed row expects; OUT_CALC leaves it to the predictor.
	typedef enum logic [2:0] {
		OUT_CALC,
		OUT_NONE,
		OUT_DATA,
		OUT_CLOSE,
		OUT_CUT
	} outcome_t;

	typedef enum logic {
		ROW_RX,
		ROW_CFG
	} row_kind_t;

	// A received byte, or a register write when kind is ROW_CFG.
	typedef struct packed {
		row_kind_t                    kind;
		bsfr_pkg::cfg_idx_t           target;
		logic [bsfr_pkg::BYTE_W-1:0]  value;
		outcome_t                     outcome;
	} dir_row_t;

	dir_row_t directed_rows [29] = '{
		// Reset settings: hunting ignores data and escapes, then one stuffed frame.
		'{ROW_RX,  bsfr_pkg::CFG_FLAG,    8'h00, OUT_NONE},
		'{ROW_RX,  bsfr_pkg::CFG_FLAG,    8'hFF, OUT_NONE},
		'{ROW_RX,  bsfr_pkg::CFG_FLAG,    8'h7D, OUT_NONE},
		'{ROW_RX,  bsfr_pkg::CFG_FLAG,    8'h7E, OUT_DATA},
		'{ROW_RX,  bsfr_pkg::CFG_FLAG,    8'h00, OUT_DATA},
		'{ROW_RX,  bsfr_pkg::CFG_FLAG,    8'hFF, OUT_DATA},
		'{ROW_RX,  bsfr_pkg::CFG_FLAG,    8'h7D, OUT_NONE},
		'{ROW_RX,  bsfr_pkg::CFG_FLAG,    8'h7E, OUT_DATA},
		'{ROW_RX,  bsfr_pkg::CFG_FLAG,    8'h7D, OUT_NONE},
		'{ROW_RX,  bsfr_pkg::CFG_FLAG,    8'h7D, OUT_DATA},
		'{ROW_RX,  bsfr_pkg::CFG_FLAG,    8'h7E, OUT_CLOSE},
		// An empty frame: two flags back to back.
		'{ROW_RX,  bsfr_pkg::CFG_FLAG,    8'h7E, OUT_DATA},
		'{ROW_RX,  bsfr_pkg::CFG_FLAG,    8'h7E, OUT_CLOSE},
		// A length of zero acts as two: the closing flag and a data byte are cut.
		'{ROW_CFG, bsfr_pkg::CFG_MAX_LEN, 8'd0,  OUT_CALC},
		'{ROW_RX,  bsfr_pkg::CFG_FLAG,    8'h7E, OUT_DATA},
		'{ROW_RX,  bsfr_pkg::CFG_FLAG,    8'h7D, OUT_NONE},
		'{ROW_RX,  bsfr_pkg::CFG_FLAG,    8'h7D, OUT_DATA},
		'{ROW_RX,  bsfr_pkg::CFG_FLAG,    8'h7E, OUT_CUT},
		'{ROW_RX,  bsfr_pkg::CFG_FLAG,    8'h7E, OUT_DATA},
		'{ROW_RX,  bsfr_pkg::CFG_FLAG,    8'h42, OUT_DATA},
		'{ROW_RX,  bsfr_pkg::CFG_FLAG,    8'h7D, OUT_NONE},
		'{ROW_RX,  bsfr_pkg::CFG_FLAG,    8'h99, OUT_CUT},
		// Flag equal to escape: it opens a frame, then escapes itself inside it.
		'{ROW_CFG, bsfr_pkg::CFG_FLAG,    8'hA5, OUT_CALC},
		'{ROW_CFG, bsfr_pkg::CFG_ESCAPE,  8'hA5, OUT_CALC},
		'{ROW_CFG, bsfr_pkg::CFG_MAX_LEN, 8'd1,  OUT_CALC},
		'{ROW_RX,  bsfr_pkg::CFG_FLAG,    8'hA5, OUT_DATA},
		'{ROW_RX,  bsfr_pkg::CFG_FLAG,    8'hA5, OUT_NONE},
		'{ROW_RX,  bsfr_pkg::CFG_FLAG,    8'hA5, OUT_DATA},
		'{ROW_RX,  bsfr_pkg::CFG_FLAG,    8'h3C, OUT_CUT}
	};

	logic clk;
	logic arst_n;
	outcome_t rx_outcome;

	bsfr_rx_if  rx_chan ();
	bsfr_res_if res_chan ();
	bsfr_cfg_if cfg_chan ();

	byte_stuffed_frame_receiver_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_chan  (rx_chan),
		.res_chan (res_chan),
		.cfg_chan (cfg_chan)
	);

	// Deframer state as the testbench predicts it.
	logic [bsfr_pkg::BYTE_W-1:0] cur_flag    = bsfr_pkg::FLAG_RESET;
	logic [bsfr_pkg::BYTE_W-1:0] cur_escape  = bsfr_pkg::ESCAPE_RESET;
	logic [bsfr_pkg::BYTE_W-1:0] cur_max_len = bsfr_pkg::MAX_LEN_RESET;
	logic [bsfr_pkg::BYTE_W-1:0] frame_bytes = '0;
	bsfr_pkg::phase_t            rx_phase    = bsfr_pkg::PH_HUNT;
	bsfr_pkg::result_t           pending_results [$];

	// Settings the stimulus shapes its frames for.
	logic [bsfr_pkg::BYTE_W-1:0] stim_flag;
	logic [bsfr_pkg::BYTE_W-1:0] stim_escape;
	logic [bsfr_pkg::BYTE_W-1:0] stim_len;
	bit                calm = 1'b0;
	int unsigned       stim_items = 0;

	int unsigned items_counted   = 0;
	int unsigned results_checked = 0;
	int unsigned frames_closed   = 0;
	int unsigned frames_cut      = 0;
	int unsigned reg_writes      = 0;
	int unsigned errors          = 0;
	int unsigned idle_cycles     = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		if ($urandom_range(0, 6) == 0)
			return int'($urandom_range(12, 40));
		return int'($urandom_range(1, 3));
	endfunction

	// Emit one frame byte, or cut the frame when it is already at its limit.
	task automatic frame_push(input logic [bsfr_pkg::BYTE_W-1:0] b, input bit closing,
		output bsfr_pkg::result_t r);
		logic [bsfr_pkg::BYTE_W-1:0] lim;
		lim = (cur_max_len < bsfr_pkg::MIN_FRAME_LEN) ? bsfr_pkg::MIN_FRAME_LEN : cur_max_len;
		if (frame_bytes >= lim) begin
			rx_phase = bsfr_pkg::PH_HUNT;
			frame_bytes = '0;
			r = {{bsfr_pkg::BYTE_W{1'b0}}, 1'b1, 1'b1};
		end else begin
			frame_bytes = frame_bytes + 1'b1;
			if (closing) begin
				rx_phase = bsfr_pkg::PH_HUNT;
				frame_bytes = '0;
				r = {b, 1'b1, 1'b0};
			end else begin
				rx_phase = bsfr_pkg::PH_FRAME;
				r = {b, 1'b0, 1'b0};
			end
		end
	endtask

	// Advance the predicted deframer by one received byte.
	task automatic unstuff_byte(input logic [bsfr_pkg::BYTE_W-1:0] b, output bit yields,
		output bit counted, output bsfr_pkg::result_t r);
		yields = 1'b0;
		counted = 1'b1;
		r = '0;
		case (rx_phase)
			bsfr_pkg::PH_FRAME: begin
				if (b == cur_escape) begin
					rx_phase = bsfr_pkg::PH_ESC;
				end else begin
					frame_push(b, b == cur_flag, r);
					yields = 1'b1;
				end
			end
			bsfr_pkg::PH_ESC: begin
				frame_push(b, 1'b0, r);
				yields = 1'b1;
			end
			default: begin
				rx_phase = bsfr_pkg::PH_HUNT;
				if (b == cur_flag) begin
					frame_bytes = 8'd1;
					rx_phase = bsfr_pkg::PH_FRAME;
					r = {b, 1'b0, 1'b0};
					yields = 1'b1;
				end else begin
					counted = 1'b0;
				end
			end
		endcase
	endtask

	task automatic note_mismatch(input string field, input int want, input int got);
		errors++;
		$display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
	endtask

	// Compare one result beat with the oldest expectation.
	task automatic check_result(input bsfr_pkg::result_t got);
		bsfr_pkg::result_t want;
		results_checked++;
		if (got.frame_end)
			if (got.overflow)
				frames_cut++;
			else
				frames_closed++;
		if (pending_results.size() == 0) begin
			errors++;
			$display("%0t ns: unexpected result, expected none, got %02h/%0b/%0b",
				$time, got.data_byte, got.frame_end, got.overflow);
		end else begin
			want = pending_results.pop_front();
			if (got.data_byte !== want.data_byte)
				note_mismatch("data_byte", int'(want.data_byte), int'(got.data_byte));
			if (got.frame_end !== want.frame_end)
				note_mismatch("frame_end", int'(want.frame_end), int'(got.frame_end));
			if (got.overflow !== want.overflow)
				note_mismatch("overflow", int'(want.overflow), int'(got.overflow));
		end
	endtask

	// Watch every channel at the clock edge: register writes, bytes in, results out.
	always @(posedge clk) begin
		bit                yields;
		bit                counted;
		bsfr_pkg::result_t calc;
		if (arst_n) begin
			idle_cycles++;
			if (cfg_chan.valid && cfg_chan.ready) begin
				idle_cycles = 0;
				reg_writes++;
				case (cfg_chan.index)
					bsfr_pkg::CFG_FLAG:    cur_flag = cfg_chan.data;
					bsfr_pkg::CFG_ESCAPE:  cur_escape = cfg_chan.data;
					bsfr_pkg::CFG_MAX_LEN: cur_max_len = cfg_chan.data;
					default: ;
				endcase
			end
			if (rx_chan.valid && rx_chan.ready) begin
				idle_cycles = 0;
				unstuff_byte(rx_chan.rx_byte, yields, counted, calc);
				if (counted)
					items_counted++;
				case (rx_outcome)
					OUT_CALC: ;
					OUT_NONE: yields = 1'b0;
					OUT_DATA: begin
						yields = 1'b1;
						calc = {rx_chan.rx_byte, 1'b0, 1'b0};
					end
					OUT_CLOSE: begin
						yields = 1'b1;
						calc = {rx_chan.rx_byte, 1'b1, 1'b0};
					end
					default: begin
						yields = 1'b1;
						calc = {{bsfr_pkg::BYTE_W{1'b0}}, 1'b1, 1'b1};
					end
				endcase
				if (yields)
					pending_results.push_back(calc);
			end
			if (res_chan.valid && res_chan.ready) begin
				idle_cycles = 0;
				check_result({res_chan.data_byte, res_chan.frame_end, res_chan.overflow});
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t ns: no beat accepted for %0d cycles", $time, STALL_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Result sink with random back-pressure, switched off in calm stretches.
	initial begin
		int stall;
		stall = 0;
		res_chan.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				res_chan.ready <= 1'b0;
				stall--;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				res_chan.ready <= 1'b0;
				stall = pick_gap() - 1;
			end else begin
				res_chan.ready <= 1'b1;
			end
		end
	end

	// Offer one byte, possibly after a gap, and return at the edge that takes it.
	task automatic send_rx(input logic [bsfr_pkg::BYTE_W-1:0] b, input outcome_t outcome);
		int gap;
		gap = (!calm && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			rx_chan.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_chan.valid <= 1'b1;
		rx_chan.rx_byte <= b;
		rx_outcome <= outcome;
		do @(posedge clk); while (rx_chan.ready !== 1'b1);
	endtask

	// Stop sending, wait for every expected result, then let the pipeline empty.
	task automatic quiesce();
		rx_chan.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves valid high so that writes can follow back to back.
	task automatic write_reg(input logic [bsfr_pkg::CFG_IDX_W-1:0] idx,
		input logic [bsfr_pkg::BYTE_W-1:0] val);
		cfg_chan.valid <= 1'b1;
		cfg_chan.index <= idx;
		cfg_chan.data <= val;
		do @(posedge clk); while (cfg_chan.ready !== 1'b1);
	endtask

	// Some line noise, then a stuffed frame; now and then the frame is left broken.
	task automatic send_frame();
		logic [bsfr_pkg::BYTE_W-1:0] d;
		int lim;
		int body;
		lim = int'((stim_len < bsfr_pkg::MIN_FRAME_LEN) ? bsfr_pkg::MIN_FRAME_LEN : stim_len);
		repeat ($urandom_range(0, 2)) begin
			d = 8'($urandom_range(0, 255));
			if (d == stim_flag)
				d = ~d;
			send_rx(d, OUT_CALC);
			stim_items++;
		end
		send_rx(stim_flag, OUT_CALC);
		stim_items++;
		body = ($urandom_range(0, 7) == 0) ? lim - 2 + int'($urandom_range(0, 3))
			: int'($urandom_range(0, 10));
		repeat (body) begin
			case ($urandom_range(0, 7))
				0: d = stim_flag;
				1: d = stim_escape;
				default: d = 8'($urandom_range(0, 255));
			endcase
			if (d == stim_flag || d == stim_escape) begin
				send_rx(stim_escape, OUT_CALC);
				stim_items++;
			end
			send_rx(d, OUT_CALC);
			stim_items++;
		end
		if ($urandom_range(0, 11) != 0) begin
			send_rx(stim_flag, OUT_CALC);
			stim_items++;
		end else if ($urandom_range(0, 1) == 0) begin
			send_rx(stim_escape, OUT_CALC);
			stim_items++;
		end
	endtask

	initial begin
		int phase_no;
		int unsigned start;
		bit cfg_open;
		arst_n <= 1'b0;
		rx_chan.valid <= 1'b0;
		rx_chan.rx_byte <= '0;
		rx_outcome <= OUT_CALC;
		cfg_chan.valid <= 1'b0;
		cfg_chan.index <= '0;
		cfg_chan.data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows; register writes wait until the block has gone quiet.
		cfg_open = 1'b0;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				if (!cfg_open)
					quiesce();
				write_reg(directed_rows[i].target, directed_rows[i].value);
				cfg_open = 1'b1;
			end else begin
				if (cfg_open)
					cfg_chan.valid <= 1'b0;
				send_rx(directed_rows[i].value, directed_rows[i].outcome);
				cfg_open = 1'b0;
			end
		end

		// Random frames under a sequence of settings, extremes first.
		phase_no = 0;
		while (stim_items < RANDOM_ITEMS) begin
			case (phase_no)
				0: {stim_flag, stim_escape, stim_len} = {8'h7E, 8'h7D, 8'd19};
				1: {stim_flag, stim_escape, stim_len} = {8'h00, 8'hFF, 8'd255};
				2: {stim_flag, stim_escape, stim_len} = {8'hFF, 8'h00, 8'd2};
				3: {stim_flag, stim_escape, stim_len} = {8'hA5, 8'hA5, 8'd8};
				default: begin
					stim_flag = 8'($urandom_range(0, 255));
					stim_escape = ($urandom_range(0, 3) == 0) ? stim_flag
						: 8'($urandom_range(0, 255));
					stim_len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 1))
						: 8'($urandom_range(2, 24));
				end
			endcase
			quiesce();
			write_reg(bsfr_pkg::CFG_FLAG, stim_flag);
			write_reg(bsfr_pkg::CFG_ESCAPE, stim_escape);
			write_reg(bsfr_pkg::CFG_MAX_LEN, stim_len);
			write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
			cfg_chan.valid <= 1'b0;
			calm = (phase_no % 3 == 2);
			start = stim_items;
			while (stim_items - start < 70 && stim_items < RANDOM_ITEMS)
				send_frame();
			phase_no++;
		end
		calm = 1'b0;
		quiesce();

		$display("Covered %0d framed bytes and %0d register writes over %0d random settings.",
			items_counted, reg_writes, phase_no);
		$display("Checked %0d results: %0d frames closed by a flag, %0d cut at the limit.",
			results_checked, frames_closed, frames_cut);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== byte_stuffed_frame_receiver_core.f =====
src/bsfr_pkg.sv
src/bsfr_if.sv
src/bsfr_front.sv
src/bsfr_fifo.sv
src/bsfr_back.sv
src/byte_stuffed_frame_receiver_core.sv
src/bsfr_checker.sv
tb/byte_stuffed_frame_receiver_core_tb.sv
